### rtl/ror_pkg.sv
// ror_pkg: shared types for the rectangle overlap ratio block
// no dependencies; used by rect_overlap_ratio_top
package ror_pkg;

    // control tag that travels with each transaction down the pipeline
    typedef struct packed {
        logic vld;
        logic degen;
    } t_pipe_tag;

endpackage

### rtl/rect_overlap_ratio_top.sv
// rect_overlap_ratio_top: intersection area of two rectangles over the smaller area
// depends on ror_pkg (pipeline tag type)
//
// channel   direction  handshake             payload
// command   in         start high, busy low  i_first_*, i_second_* (left, top, width, height)
// result    out        o_valid strobe        o_overlap_ratio, o_overlap_area, o_degenerate
//
// one transaction per cycle; results come out in the order in which the starts were taken
// the pipeline is 3 front stages (axis overlap, area multiplies, min) followed by a
// restoring divider with one quotient bit per stage (FRACTION_BITS + 1 stages)
// busy is always low: the receiver cannot stall, so nothing in the pipeline ever waits
// synchronous active-low reset clears the valid bits and the divider tags; other payload registers are not reset
module rect_overlap_ratio_top #(
    parameter int COORD_BITS    = 12,
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [COORD_BITS-1:0]      i_first_left,
    input  logic [COORD_BITS-1:0]      i_first_top,
    input  logic [COORD_BITS-1:0]      i_first_width,
    input  logic [COORD_BITS-1:0]      i_first_height,
    input  logic [COORD_BITS-1:0]      i_second_left,
    input  logic [COORD_BITS-1:0]      i_second_top,
    input  logic [COORD_BITS-1:0]      i_second_width,
    input  logic [COORD_BITS-1:0]      i_second_height,
    output logic                       o_valid,
    output logic [FRACTION_BITS:0]     o_overlap_ratio,
    output logic [2*COORD_BITS-1:0]    o_overlap_area,
    output logic                       o_degenerate
);

    localparam int CB = COORD_BITS;
    localparam int AB = 2 * COORD_BITS;
    localparam int QB = FRACTION_BITS + 1;
    localparam int NS = FRACTION_BITS + 1;
    localparam logic [QB-1:0] RATIO_ONE = QB'(1) << FRACTION_BITS;

    // overlap along one axis, zero when apart or touching; edges kept at CB+1 bits
    function automatic logic [CB-1:0] axis_ov(
        input logic [CB-1:0] a0,
        input logic [CB-1:0] alen,
        input logic [CB-1:0] b0,
        input logic [CB-1:0] blen
    );
        logic [CB:0] a1;
        logic [CB:0] b1;
        logic [CB:0] lo;
        logic [CB:0] hi;
        logic [CB:0] d;
        a1 = {1'b0, a0} + {1'b0, alen};
        b1 = {1'b0, b0} + {1'b0, blen};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (a1 < b1) ? a1 : b1;
        d  = (hi > lo) ? (hi - lo) : '0;
        // overlap never exceeds either length, so it fits in CB bits
        return d[CB-1:0];
    endfunction

    assign busy = 1'b0;

    // stage 1: axis overlaps
    logic          r_s1_vld;
    logic [CB-1:0] r_s1_ox, r_s1_oy;
    logic [CB-1:0] r_s1_fw, r_s1_fh, r_s1_sw, r_s1_sh;
    logic [CB-1:0] n_s1_ox, n_s1_oy;

    assign n_s1_ox = axis_ov(i_first_left, i_first_width, i_second_left, i_second_width);
    assign n_s1_oy = axis_ov(i_first_top, i_first_height, i_second_top, i_second_height);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
        r_s1_ox <= n_s1_ox;
        r_s1_oy <= n_s1_oy;
        r_s1_fw <= i_first_width;
        r_s1_fh <= i_first_height;
        r_s1_sw <= i_second_width;
        r_s1_sh <= i_second_height;
    end

    // stage 2: intersection area and both rectangle areas
    logic          r_s2_vld;
    logic [AB-1:0] r_s2_common, r_s2_area1, r_s2_area2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_common <= AB'(r_s1_ox) * AB'(r_s1_oy);
        r_s2_area1  <= AB'(r_s1_fw) * AB'(r_s1_fh);
        r_s2_area2  <= AB'(r_s1_sw) * AB'(r_s1_sh);
    end

    // stage 3: smaller area and degenerate flag
    logic          r_s3_vld;
    logic          r_s3_degen;
    logic [AB-1:0] r_s3_common, r_s3_small;
    logic [AB-1:0] n_s3_small;

    assign n_s3_small = (r_s2_area1 < r_s2_area2) ? r_s2_area1 : r_s2_area2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_common <= r_s2_common;
        r_s3_small  <= n_s3_small;
        r_s3_degen  <= (n_s3_small == '0);
    end

    // restoring divider, one quotient bit per stage, msb first
    // intersection never exceeds the smaller area, so the first bit is the integer part
    logic [AB-1:0]      r_rem  [NS];
    logic [QB-1:0]      r_quo  [NS];
    logic [AB-1:0]      r_div  [NS];
    logic [AB-1:0]      r_area [NS];
    ror_pkg::t_pipe_tag r_tag  [NS];

    logic [AB:0]        n_trial [NS];
    logic               n_ge    [NS];
    logic [AB:0]        n_diff  [NS];
    logic [QB-1:0]      n_quo   [NS];
    logic [AB-1:0]      n_div   [NS];
    logic [AB-1:0]      n_area  [NS];
    ror_pkg::t_pipe_tag n_tag   [NS];

    for (genvar k = 0; k < NS; k++) begin : g_div
        if (k == 0) begin : g_first
            assign n_trial[k]   = {1'b0, r_s3_common};
            assign n_div[k]     = r_s3_small;
            assign n_area[k]    = r_s3_common;
            assign n_tag[k].vld   = r_s3_vld;
            assign n_tag[k].degen = r_s3_degen;
            assign n_quo[k]     = {{(QB-1){1'b0}}, n_ge[k]};
        end else begin : g_next
            assign n_trial[k] = {r_rem[k-1], 1'b0};
            assign n_div[k]   = r_div[k-1];
            assign n_area[k]  = r_area[k-1];
            assign n_tag[k]   = r_tag[k-1];
            assign n_quo[k]   = {r_quo[k-1][QB-2:0], n_ge[k]};
        end

        assign n_ge[k]   = (n_trial[k] >= {1'b0, n_div[k]});
        assign n_diff[k] = n_ge[k] ? (n_trial[k] - {1'b0, n_div[k]}) : n_trial[k];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tag[k] <= '0;
            end else begin
                r_tag[k] <= n_tag[k];
            end
            // remainder stays below the divisor, so AB bits hold it
            r_rem[k]  <= n_diff[k][AB-1:0];
            r_quo[k]  <= n_quo[k];
            r_div[k]  <= n_div[k];
            r_area[k] <= n_area[k];
        end
    end

    assign o_valid         = r_tag[NS-1].vld;
    assign o_degenerate    = r_tag[NS-1].degen;
    assign o_overlap_area  = r_area[NS-1];
    // a zero divisor leaves an all-ones quotient; degenerate forces zero
    assign o_overlap_ratio = r_tag[NS-1].degen ? '0 : r_quo[NS-1];

    a_ratio_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_overlap_ratio <= RATIO_ONE)
        else $error("overlap ratio above one");

    a_zero_area_zero_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overlap_area == '0) |-> o_overlap_ratio == '0)
        else $error("nonzero ratio with no intersection");

    a_degen_no_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_degenerate) |-> o_overlap_area == '0)
        else $error("degenerate rectangle with nonzero intersection");

    a_full_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overlap_ratio == RATIO_ONE) |-> (!o_degenerate && o_overlap_area != '0))
        else $error("full ratio without a real intersection");

endmodule

### verif/tb_rect_overlap_ratio_top.sv
// tb_rect_overlap_ratio_top: self-checking bench for the rectangle overlap ratio block
// depends on rect_overlap_ratio_top only; predicts area, ratio and degenerate flag per pair
// directed corner cases first, then random pairs with bursty start and drain pauses
module tb_rect_overlap_ratio_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS    = 12;
    localparam int FRACTION_BITS = 16;
    localparam int CMAX          = (1 << COORD_BITS) - 1;
    localparam int RANDOM_PAIRS  = 1330;
    localparam int IDLE_LIMIT    = 2000;
    localparam int TAIL_CYCLES   = 3 * (FRACTION_BITS + 4);
    localparam int MAX_PRINTS    = 40;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct {
        t_coord first_left, first_top, first_width, first_height;
        t_coord second_left, second_top, second_width, second_height;
        bit     drain;
    } t_rect_pair;

    typedef struct packed {
        logic [FRACTION_BITS:0]     ratio;
        logic [2*COORD_BITS-1:0]    area;
        logic                       degen;
    } t_overlap;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    t_coord i_first_left    = '0;
    t_coord i_first_top     = '0;
    t_coord i_first_width   = '0;
    t_coord i_first_height  = '0;
    t_coord i_second_left   = '0;
    t_coord i_second_top    = '0;
    t_coord i_second_width  = '0;
    t_coord i_second_height = '0;
    logic                       o_valid;
    logic [FRACTION_BITS:0]     o_overlap_ratio;
    logic [2*COORD_BITS-1:0]    o_overlap_area;
    logic                       o_degenerate;

    t_rect_pair pair_q[$];
    t_overlap   overlap_q[$];
    t_rect_pair cur_pair;
    int         mismatches = 0;
    int         burst_left = 1;
    int         gap_left   = 0;
    int         idle_cycles = 0;

    rect_overlap_ratio_top #(
        .COORD_BITS   (COORD_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_first_left   (i_first_left),
        .i_first_top    (i_first_top),
        .i_first_width  (i_first_width),
        .i_first_height (i_first_height),
        .i_second_left  (i_second_left),
        .i_second_top   (i_second_top),
        .i_second_width (i_second_width),
        .i_second_height(i_second_height),
        .o_valid        (o_valid),
        .o_overlap_ratio(o_overlap_ratio),
        .o_overlap_area (o_overlap_area),
        .o_degenerate   (o_degenerate)
    );

    always #5 i_clk = ~i_clk;

    // overlap along one axis, edges kept one bit wider so they never wrap
    function automatic logic [COORD_BITS:0] axis_span(t_coord a0, t_coord alen,
                                                      t_coord b0, t_coord blen);
        logic [COORD_BITS:0] a1, b1, lo, hi;
        a1 = {1'b0, a0} + {1'b0, alen};
        b1 = {1'b0, b0} + {1'b0, blen};
        lo = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? hi - lo : '0;
    endfunction

    function automatic t_overlap compute_overlap(t_rect_pair p);
        logic [COORD_BITS:0]     span_x, span_y;
        logic [2*COORD_BITS-1:0] common, area_first, area_second, smaller;
        logic [63:0]             quotient;
        t_overlap                res;
        span_x      = axis_span(p.first_left, p.first_width, p.second_left, p.second_width);
        span_y      = axis_span(p.first_top, p.first_height, p.second_top, p.second_height);
        common      = (2*COORD_BITS)'(span_x) * (2*COORD_BITS)'(span_y);
        area_first  = (2*COORD_BITS)'(p.first_width) * (2*COORD_BITS)'(p.first_height);
        area_second = (2*COORD_BITS)'(p.second_width) * (2*COORD_BITS)'(p.second_height);
        smaller     = (area_first < area_second) ? area_first : area_second;
        res.area    = common;
        res.degen   = (smaller == '0);
        res.ratio   = '0;
        if (!res.degen) begin
            quotient  = (64'(common) << FRACTION_BITS) / 64'(smaller);
            res.ratio = quotient[FRACTION_BITS:0];
        end
        return res;
    endfunction

    task automatic add_pair(int fl, int ft, int fw, int fh, int sl, int st, int sw, int sh,
                            bit drain = 1'b0);
        t_rect_pair p;
        p.first_left    = t_coord'(fl);
        p.first_top     = t_coord'(ft);
        p.first_width   = t_coord'(fw);
        p.first_height  = t_coord'(fh);
        p.second_left   = t_coord'(sl);
        p.second_top    = t_coord'(st);
        p.second_width  = t_coord'(sw);
        p.second_height = t_coord'(sh);
        p.drain         = drain;
        pair_q.push_back(p);
    endtask

    function automatic int rand_size();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, CMAX) : $urandom_range(1, 63);
    endfunction

    task automatic add_random_pair(bit drain);
        int fl, ft, fw, fh, sl, st, sw, sh;
        fl = $urandom_range(0, CMAX);
        ft = $urandom_range(0, CMAX);
        fw = rand_size();
        fh = rand_size();
        sw = rand_size();
        sh = rand_size();
        // second origin placed so the pair mostly overlaps
        sl = fl + fw - $urandom_range(0, fw + sw);
        st = ft + fh - $urandom_range(0, fh + sh);
        case ($urandom_range(0, 9))
            4: begin
                if ($urandom_range(0, 1)) sl = fl + fw + $urandom_range(1, 20);
                else st = ft + fh + $urandom_range(1, 20);
            end
            5: begin
                // shared edge or corner
                if ($urandom_range(0, 1)) sl = fl + fw;
                if ($urandom_range(0, 1)) st = ft + fh;
                else sl = fl - sw;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: fw = 0;
                    1: fh = 0;
                    2: sw = 0;
                    default: sh = 0;
                endcase
            end
            7: begin
                if (fw > 0) sl = fl + $urandom_range(0, fw - 1);
                if (fh > 0) st = ft + $urandom_range(0, fh - 1);
            end
            8, 9: begin
                fl = $urandom; ft = $urandom; fw = $urandom; fh = $urandom;
                sl = $urandom; st = $urandom; sw = $urandom; sh = $urandom;
            end
            default: ;
        endcase
        add_pair(fl, ft, fw, fh, sl, st, sw, sh, drain);
    endtask

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic new_burst();
        if ($urandom_range(0, 7) == 0) begin
            burst_left = $urandom_range(100, 300);
            gap_left   = 0;
        end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = $urandom_range(1, 25);
        end
    endtask

    // driver: one transaction per accepted start
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                overlap_q.push_back(compute_overlap(cur_pair));
            end
            if (start && busy) begin
                // hold the pair until it is taken
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pair_q.size() == 0 || (pair_q[0].drain && overlap_q.size() != 0)) begin
                start <= 1'b0;
            end else begin
                cur_pair = pair_q.pop_front();
                i_first_left    <= cur_pair.first_left;
                i_first_top     <= cur_pair.first_top;
                i_first_width   <= cur_pair.first_width;
                i_first_height  <= cur_pair.first_height;
                i_second_left   <= cur_pair.second_left;
                i_second_top    <= cur_pair.second_top;
                i_second_width  <= cur_pair.second_width;
                i_second_height <= cur_pair.second_height;
                start <= 1'b1;
                burst_left--;
                if (burst_left <= 0) new_burst();
            end
        end
    end

    // monitor: results are strobed, compared against the oldest prediction
    always @(posedge i_clk) begin
        t_overlap want;
        if (i_rst_n && o_valid) begin
            if (overlap_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result ratio=%0d area=%0d degen=%0b",
                                          o_overlap_ratio, o_overlap_area, o_degenerate));
            end else begin
                want = overlap_q.pop_front();
                if (o_overlap_ratio !== want.ratio)
                    report_mismatch($sformatf("overlap_ratio got %0d want %0d",
                                              o_overlap_ratio, want.ratio));
                if (o_overlap_area !== want.area)
                    report_mismatch($sformatf("overlap_area got %0d want %0d",
                                              o_overlap_area, want.area));
                if (o_degenerate !== want.degen)
                    report_mismatch($sformatf("degenerate got %0b want %0b",
                                              o_degenerate, want.degen));
            end
        end
    end

    // watchdog on cycles with no transaction in either direction
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_rect_overlap_ratio_top: errors");
            $finish;
        end
    end

    initial begin
        // directed corners
        add_pair(0, 0, 0, 0, 0, 0, 0, 0);
        add_pair(0, 0, CMAX, CMAX, 0, 0, CMAX, CMAX);
        add_pair(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX);
        add_pair(100, 100, 50, 40, 110, 105, 10, 10);
        add_pair(10, 20, 30, 40, 25, 35, 30, 40);
        add_pair(10, 10, 20, 20, 31, 10, 20, 20);
        add_pair(10, 10, 20, 20, 10, 31, 20, 20);
        add_pair(10, 10, 20, 20, 30, 10, 20, 20);
        add_pair(10, 10, 20, 20, 10, 30, 20, 20);
        add_pair(10, 10, 20, 20, 30, 30, 5, 5);
        add_pair(10, 10, 0, 20, 10, 10, 20, 20);
        add_pair(10, 10, 20, 0, 10, 10, 20, 20);
        add_pair(10, 10, 20, 20, 12, 12, 5, 0);
        add_pair(10, 10, 20, 20, 12, 12, 0, 5);
        add_pair(0, 0, CMAX, CMAX, 2000, 3000, 1, 1);
        add_pair(0, 0, 3, 1, 1, 0, 3, 1);
        add_pair(0, 0, CMAX, CMAX, CMAX - 1, CMAX - 1, CMAX, CMAX);
        add_pair(CMAX, 0, CMAX, 1, 0, 0, CMAX, 1);
        add_pair(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'h555, 12'hAAA);
        add_pair(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        for (int i = 0; i < RANDOM_PAIRS; i++) add_random_pair(i % 450 == 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pair_q.size() != 0 || start) @(posedge i_clk);
        while (overlap_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_rect_overlap_ratio_top: clean");
        end else begin
            $display("tb_rect_overlap_ratio_top: errors");
        end
        $finish;
    end
endmodule

### filelist.f
rtl/ror_pkg.sv
rtl/rect_overlap_ratio_top.sv
verif/tb_rect_overlap_ratio_top.sv
